### src/bsfs_pkg.sv
// Shared types, widths and constants for the Biot-Savart field accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bsfs_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_W = 32;
    localparam int ACC_W = 64;
    localparam logic signed [WORD_W-1:0] GAIN_RESET = WORD_W'(100 << FRAC_BITS);

    // queue entry between front and back
    typedef struct packed {
        logic signed [WORD_W-1:0] rx;
        logic signed [WORD_W-1:0] ry;
        logic signed [WORD_W-1:0] rz;
        logic signed [WORD_W-1:0] dx;
        logic signed [WORD_W-1:0] dy;
        logic signed [WORD_W-1:0] dz;
        logic                     r_ovf;
        logic                     last;
    } bsfs_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] fx;
        logic signed [WORD_W-1:0] fy;
        logic signed [WORD_W-1:0] fz;
        logic                     sing;
        logic                     ovf;
    } bsfs_result_t;

    localparam int ITEM_W = $bits(bsfs_item_t);
    localparam int RES_W = $bits(bsfs_result_t);
endpackage
`default_nettype wire

### src/bsfs_front.sv
// Front end: accepts input beats, forms saturated r = Q - P.
// Depends on bsfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsfs_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [32*9-1:0]           in_data,
    input  wire logic                      in_last,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output bsfs_pkg::bsfs_item_t           q_item
);
    import bsfs_pkg::*;

    logic                  valid_reg;
    bsfs_item_t            item_reg;
    bsfs_item_t            item_next;
    logic [2:0]            ovf_bits;
    logic signed [WORD_W:0] dif [3];
    logic signed [WORD_W-1:0] rs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif[i] = {in_data[i*32+31], in_data[i*32 +: 32]}
                   - {in_data[(i+6)*32+31], in_data[(i+6)*32 +: 32]};
            if (dif[i][WORD_W] != dif[i][WORD_W-1])
            begin
                ovf_bits[i] = 1'b1;
                rs[i] = dif[i][WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
            end
            else
            begin
                ovf_bits[i] = 1'b0;
                rs[i] = dif[i][WORD_W-1:0];
            end
        end
        item_next.rx = rs[0];
        item_next.ry = rs[1];
        item_next.rz = rs[2];
        item_next.dx = in_data[3*32 +: 32];
        item_next.dy = in_data[4*32 +: 32];
        item_next.dz = in_data[5*32 +: 32];
        item_next.r_ovf = |ovf_bits;
        item_next.last = in_last;
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end
endmodule
`default_nettype wire

### src/bsfs_queue.sv
// Two-entry queue between front and back.
// Depends on bsfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsfs_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_valid,
    output logic                      wr_ready,
    input  wire bsfs_pkg::bsfs_item_t wr_item,
    output logic                      rd_valid,
    input  wire logic                 rd_ready,
    output bsfs_pkg::bsfs_item_t      rd_item
);
    import bsfs_pkg::*;

    bsfs_item_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_item = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= !wp_reg;
            if (do_rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_item;
    end
endmodule
`default_nettype wire

### src/bsfs_back.sv
// Back end: sequencer with a shared 32x32 multiplier, isqrt, restoring divider,
// accumulators and output scaling. Depends on bsfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsfs_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire bsfs_pkg::bsfs_item_t       q_item,
    input  wire logic signed [31:0]         gain,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output bsfs_pkg::bsfs_result_t          res
);
    import bsfs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_DIV1  = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]  state_reg;
    bsfs_item_t  it_reg;
    logic [3:0]  step_reg;
    logic [1:0]  comp_reg;
    logic signed [63:0] prod [9];
    logic signed [63:0] sum_reg [3];
    logic        sing_reg;
    logic        ovf_reg;
    logic [63:0] m2_reg;
    logic [63:0] m_reg;
    logic [63:0] sx_reg;
    logic [63:0] sbit_reg;
    logic [63:0] sres_reg;
    logic [63:0] mag_reg;
    logic        neg_reg;
    logic [63:0] q_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        dq_ovf_reg;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] pr_reg [9];
    bsfs_result_t res_reg;
    logic        resv_reg;
    logic [31:0] fld_reg [3];
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic        sneg_reg;
    logic [1:0]  sph_reg;

    logic [64:0] r2;
    logic        big;
    logic [63:0] qn;
    logic [63:0] sm;
    logic [63:0] gm;
    logic [63:0] lim;
    logic [63:0] tot;
    logic        sgn_neg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0: begin mul_a = it_reg.rx; mul_b = it_reg.rx; end
            4'd1: begin mul_a = it_reg.ry; mul_b = it_reg.ry; end
            4'd2: begin mul_a = it_reg.rz; mul_b = it_reg.rz; end
            4'd3: begin mul_a = it_reg.dy; mul_b = it_reg.rz; end
            4'd4: begin mul_a = it_reg.dz; mul_b = it_reg.ry; end
            4'd5: begin mul_a = it_reg.dz; mul_b = it_reg.rx; end
            4'd6: begin mul_a = it_reg.dx; mul_b = it_reg.rz; end
            4'd7: begin mul_a = it_reg.dx; mul_b = it_reg.ry; end
            4'd8: begin mul_a = it_reg.dy; mul_b = it_reg.rx; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
        for (int i = 0; i < 9; i++)
            prod[i] = pr_reg[i];

        r2 = {rem_reg, 1'b0};
        big = rem_reg[63];
        qn = {q_reg[62:0], 1'b0};

        sm = sum_reg[comp_reg][63] ? 64'(-sum_reg[comp_reg]) : 64'(sum_reg[comp_reg]);
        gm = gain[31] ? 64'(-{{32{gain[31]}}, gain}) : {32'd0, gain};
        sgn_neg = sum_reg[comp_reg][63] != gain[31];
        lim = sneg_reg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (hi_reg >= (64'd1 << FRAC_BITS))
            tot = lim + 64'd1;
        else
            tot = (hi_reg << (32 - FRAC_BITS)) + (lo_reg >> FRAC_BITS);
    end

    assign q_ready = state_reg == S_IDLE;
    assign res_valid = resv_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resv_reg <= 1'b0;
            step_reg <= '0;
            comp_reg <= '0;
            sph_reg <= '0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
            sing_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (resv_reg && res_ready && state_reg != S_OUT)
                resv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg <= q_item;
                        if (q_item.r_ovf)
                            ovf_reg <= 1'b1;
                        step_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    pr_reg[step_reg] <= mul_p;
                    if (step_reg == 4'd8)
                    begin
                        m2_reg <= 64'(prod[0]) + 64'(prod[1]) + 64'(prod[2]);
                        step_reg <= '0;
                        state_reg <= S_SQRT;
                        sph_reg <= 2'd0;
                    end
                    else
                        step_reg <= step_reg + 4'd1;
                end
                S_SQRT:
                begin
                    if (sph_reg == 2'd0)
                    begin
                        if (m2_reg == 64'd0)
                        begin
                            sing_reg <= 1'b1;
                            comp_reg <= '0;
                            state_reg <= it_reg.last ? S_SCALE : S_IDLE;
                            sph_reg <= '0;
                        end
                        else
                        begin
                            sx_reg <= m2_reg;
                            sres_reg <= '0;
                            sbit_reg <= 64'd1 << 62;
                            sph_reg <= 2'd1;
                        end
                    end
                    else if (sph_reg == 2'd1)
                    begin
                        if (sbit_reg > sx_reg)
                            sbit_reg <= sbit_reg >> 2;
                        else
                            sph_reg <= 2'd2;
                    end
                    else
                    begin
                        if (sbit_reg == 64'd0)
                        begin
                            m_reg <= sres_reg;
                            comp_reg <= '0;
                            state_reg <= S_DIV1;
                            sph_reg <= '0;
                        end
                        else
                        begin
                            if (sx_reg >= sres_reg + sbit_reg)
                            begin
                                sx_reg <= sx_reg - (sres_reg + sbit_reg);
                                sres_reg <= (sres_reg >> 1) + sbit_reg;
                            end
                            else
                                sres_reg <= sres_reg >> 1;
                            sbit_reg <= sbit_reg >> 2;
                        end
                    end
                end
                S_DIV1:
                begin
                    // start |C| / M, bit-serial
                    if (sph_reg == 2'd0)
                    begin
                        if (prod[3+2*comp_reg] >= prod[4+2*comp_reg])
                        begin
                            neg_reg <= 1'b0;
                            mag_reg <= 64'(prod[3+2*comp_reg]) - 64'(prod[4+2*comp_reg]);
                        end
                        else
                        begin
                            neg_reg <= 1'b1;
                            mag_reg <= 64'(prod[4+2*comp_reg]) - 64'(prod[3+2*comp_reg]);
                        end
                        q_reg <= '0;
                        rem_reg <= '0;
                        den_reg <= m_reg;
                        cnt_reg <= 7'd64;
                        sph_reg <= 2'd1;
                    end
                    else
                    begin
                        if (cnt_reg == 7'd0)
                        begin
                            // T known; now T*2^2F / M2 via restoring division
                            mag_reg <= q_reg;
                            q_reg <= '0;
                            rem_reg <= '0;
                            den_reg <= m2_reg;
                            cnt_reg <= 7'd64;
                            dq_ovf_reg <= 1'b0;
                            sph_reg <= 2'd0;
                            state_reg <= S_DIV2;
                        end
                        else
                        begin
                            if ({rem_reg, mag_reg[63]} >= {1'b0, den_reg})
                            begin
                                rem_reg <= 64'({rem_reg, mag_reg[63]} - {1'b0, den_reg});
                                q_reg <= {q_reg[62:0], 1'b1};
                            end
                            else
                            begin
                                rem_reg <= {rem_reg[62:0], mag_reg[63]};
                                q_reg <= {q_reg[62:0], 1'b0};
                            end
                            mag_reg <= {mag_reg[62:0], 1'b0};
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                end
                S_DIV2:
                begin
                    // 64 bits of T/M2, then 2F shifted steps, hold at 2^63-1
                    if (sph_reg == 2'd0)
                    begin
                        if (cnt_reg == 7'd0)
                        begin
                            if (q_reg[63])
                            begin
                                dq_ovf_reg <= 1'b1;
                                q_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
                                state_reg <= S_ACC;
                            end
                            else
                            begin
                                cnt_reg <= 7'(2 * FRAC_BITS);
                                sph_reg <= 2'd1;
                            end
                        end
                        else
                        begin
                            if ({rem_reg, mag_reg[63]} >= {1'b0, den_reg})
                            begin
                                rem_reg <= 64'({rem_reg, mag_reg[63]} - {1'b0, den_reg});
                                q_reg <= {q_reg[62:0], 1'b1};
                            end
                            else
                            begin
                                rem_reg <= {rem_reg[62:0], mag_reg[63]};
                                q_reg <= {q_reg[62:0], 1'b0};
                            end
                            mag_reg <= {mag_reg[62:0], 1'b0};
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == 7'd0)
                            state_reg <= S_ACC;
                        else if (q_reg[62])
                        begin
                            dq_ovf_reg <= 1'b1;
                            q_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            if (big || r2 >= {1'b0, den_reg})
                            begin
                                rem_reg <= 64'(r2 - {1'b0, den_reg});
                                q_reg <= qn | 64'd1;
                            end
                            else
                            begin
                                rem_reg <= r2[63:0];
                                q_reg <= qn;
                            end
                            cnt_reg <= cnt_reg - 7'd1;
                        end
                    end
                end
                S_ACC:
                begin
                    sph_reg <= 2'd0;
                    if (!neg_reg)
                    begin
                        if (q_reg != 64'd0
                            && sum_reg[comp_reg] > $signed(64'h7FFF_FFFF_FFFF_FFFF - q_reg))
                        begin
                            ovf_reg <= 1'b1;
                            sum_reg[comp_reg] <= 64'h7FFF_FFFF_FFFF_FFFF;
                        end
                        else
                        begin
                            ovf_reg <= ovf_reg | dq_ovf_reg;
                            sum_reg[comp_reg] <= sum_reg[comp_reg] + $signed(q_reg);
                        end
                    end
                    else
                    begin
                        if (q_reg != 64'd0
                            && sum_reg[comp_reg] < $signed(64'h8000_0000_0000_0000 + q_reg))
                        begin
                            ovf_reg <= 1'b1;
                            sum_reg[comp_reg] <= 64'h8000_0000_0000_0000;
                        end
                        else
                        begin
                            ovf_reg <= ovf_reg | dq_ovf_reg;
                            sum_reg[comp_reg] <= sum_reg[comp_reg] - $signed(q_reg);
                        end
                    end
                    if (comp_reg == 2'd2)
                    begin
                        comp_reg <= '0;
                        state_reg <= it_reg.last ? S_SCALE : S_IDLE;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        state_reg <= S_DIV1;
                    end
                end
                S_SCALE:
                begin
                    if (sph_reg == 2'd0)
                    begin
                        hi_reg <= {32'd0, sm[63:32]} * {32'd0, gm[31:0]};
                        lo_reg <= {32'd0, sm[31:0]} * {32'd0, gm[31:0]};
                        sneg_reg <= sgn_neg;
                        sph_reg <= 2'd1;
                    end
                    else
                    begin
                        if (tot > lim)
                        begin
                            ovf_reg <= 1'b1;
                            fld_reg[comp_reg] <= sneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        end
                        else
                            fld_reg[comp_reg] <= sneg_reg ? 32'(-tot) : tot[31:0];
                        sph_reg <= 2'd0;
                        if (comp_reg == 2'd2)
                        begin
                            comp_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            comp_reg <= comp_reg + 2'd1;
                    end
                end
                S_OUT:
                begin
                    // hold until the previous result beat has left
                    if (!resv_reg || res_ready)
                    begin
                        res_reg.fx <= fld_reg[0];
                        res_reg.fy <= fld_reg[1];
                        res_reg.fz <= fld_reg[2];
                        res_reg.sing <= sing_reg;
                        res_reg.ovf <= ovf_reg;
                        resv_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            sum_reg[i] <= '0;
                        sing_reg <= 1'b0;
                        ovf_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### src/biot_savart_field_sum.sv
// Biot-Savart segment accumulator, top level.
// A beat passes the front register and the two-entry queue before the back end.
// The back end runs products, root, two divisions and a sum per component (less at
// zero distance or early saturation), and scales a last item before the result beat.
// Throughput: one item at a time through the shared bit-serial divider.
// Reset (rst_n low, async): sums and flags clear, gain returns to 100.0.
`timescale 1ns / 1ps
`default_nettype none
module biot_savart_field_sum
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [287:0]  s_axis_tdata,  // query_x/y/z, seg_dx/dy/dz, seg_px/py/pz
    input  wire logic          s_axis_tlast,  // last_segment
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata,  // field_x, field_y, field_z
    output logic [1:0]         m_axis_tuser,  // singular_seen, overflow_seen
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [31:0]   cfg_data       // field_gain
);
    import bsfs_pkg::*;

    logic               f_valid;
    logic               f_ready;
    bsfs_item_t         f_item;
    logic               b_valid;
    logic               b_ready;
    bsfs_item_t         b_item;
    bsfs_result_t       r;
    logic signed [31:0] gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (cfg_valid)
            gain_reg <= cfg_data;
    end

    bsfs_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .in_last(s_axis_tlast),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    bsfs_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    bsfs_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .gain(gain_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tdata = {r.fz, r.fy, r.fx};
    assign m_axis_tuser = {r.ovf, r.sing};
endmodule
`default_nettype wire

### src/biot_savart_field_sum_chk.sv
// Port-level checker for biot_savart_field_sum, bound to the top level.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module biot_savart_field_sum_chk
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [95:0]  m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped");
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
endmodule

bind biot_savart_field_sum biot_savart_field_sum_chk u_chk (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .cfg_ready(cfg_ready)
);
`default_nettype wire
